// ===== src/ebdc_pkg.sv =====
`timescale 1ns / 1ps

package ebdc_pkg;

  // event kinds carried in tuser
  localparam logic [2:0] KIND_TICK_R   = 3'd0;
  localparam logic [2:0] KIND_TICK_L   = 3'd1;
  localparam logic [2:0] KIND_SPEED    = 3'd2;
  localparam logic [2:0] KIND_DIR      = 3'd3;
  localparam logic [2:0] KIND_TARGETS  = 3'd4;
  localparam logic [2:0] KIND_STOP     = 3'd5;

  // direction modes
  localparam logic [2:0] DIR_FWD     = 3'd0;
  localparam logic [2:0] DIR_BWD     = 3'd1;
  localparam logic [2:0] DIR_TL      = 3'd2;
  localparam logic [2:0] DIR_TR      = 3'd3;
  localparam logic [2:0] DIR_BRAKE   = 3'd4;
  localparam logic [2:0] DIR_BRAKE_L = 3'd5;
  localparam logic [2:0] DIR_BRAKE_R = 3'd6;

  // h-bridge line codes
  localparam logic [1:0] BR_OFF = 2'd0;
  localparam logic [1:0] BR_A   = 2'd1;
  localparam logic [1:0] BR_B   = 2'd2;

  localparam logic [8:0] BAL_SPAN = 9'd25;
  localparam logic [7:0] DUTY_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  spd_l;
    logic [7:0]  spd_r;
    logic [31:0] cnt_l;
    logic [31:0] cnt_r;
    logic [15:0] rem_l;
    logic [15:0] rem_r;
    logic [7:0]  pwm_l;
    logic [7:0]  pwm_r;
    logic [1:0]  br_l;
    logic [1:0]  br_r;
    logic        lamp_l;
    logic        lamp_r;
  } state_t;

  // codes above brake right leave everything as it is
  function automatic state_t dir_apply(state_t s, logic [2:0] d);
    state_t r;
    r = s;
    if (d <= DIR_BRAKE_R) begin
      unique case (d)
        DIR_FWD, DIR_TR:         r.br_l = BR_A;
        DIR_BWD, DIR_TL:         r.br_l = BR_B;
        DIR_BRAKE, DIR_BRAKE_L:  r.br_l = BR_OFF;
        default: ;
      endcase
      unique case (d)
        DIR_FWD, DIR_TL:         r.br_r = BR_A;
        DIR_BWD, DIR_TR:         r.br_r = BR_B;
        DIR_BRAKE, DIR_BRAKE_R:  r.br_r = BR_OFF;
        default: ;
      endcase
      r.mode = d;
    end
    return r;
  endfunction

  function automatic state_t speed_apply(state_t s, logic [7:0] l, logic [7:0] rr);
    state_t r;
    r = s;
    r.spd_l  = l;
    r.spd_r  = rr;
    r.pwm_l  = l;
    r.pwm_r  = rr;
    r.cnt_l  = '0;
    r.cnt_r  = '0;
    r.lamp_l = (l != 8'd0);
    r.lamp_r = (rr != 8'd0);
    // a zero side brakes; right is applied last so its mode wins
    if (l == 8'd0) r = dir_apply(r, DIR_BRAKE_L);
    if (rr == 8'd0) r = dir_apply(r, DIR_BRAKE_R);
    return r;
  endfunction

  // returns {up, down}: raise up within speed+span, else lower down within speed-span
  function automatic logic [15:0] nudge(logic [7:0] up, logic [7:0] down, logic [7:0] spd);
    logic [7:0] u;
    logic [7:0] d;
    u = up;
    d = down;
    if (({1'b0, up} < ({1'b0, spd} + BAL_SPAN)) && (up != DUTY_MAX)) begin
      u = up + 8'd1;
    end else if ((down > 8'd1) && (({2'b00, down} + {1'b0, BAL_SPAN}) > {2'b00, spd})) begin
      d = down - 8'd1;
    end
    return {u, d};
  endfunction

endpackage

// ===== src/ebdc_step.sv =====
`timescale 1ns / 1ps

module ebdc_step (
  input  ebdc_pkg::state_t st_i,
  input  logic [2:0]       kind_i,
  input  logic [15:0]      vl_i,
  input  logic [15:0]      vr_i,
  input  logic [2:0]       dir_i,
  output ebdc_pkg::state_t st_o
);

  ebdc_pkg::state_t s_tick_r;
  ebdc_pkg::state_t s_tick_l;
  ebdc_pkg::state_t s_stop;
  logic             bal_ok;
  logic [31:0]      diff;
  logic [15:0]      nud;

  // right tick: count, countdown, then balance
  always_comb begin
    s_tick_r = st_i;
    unique case (st_i.mode)
      ebdc_pkg::DIR_FWD, ebdc_pkg::DIR_TL: s_tick_r.cnt_r = st_i.cnt_r + 32'd1;
      ebdc_pkg::DIR_BWD, ebdc_pkg::DIR_TR: s_tick_r.cnt_r = st_i.cnt_r - 32'd1;
      default: ;
    endcase
    if (st_i.rem_r != 16'd0) begin
      s_tick_r.rem_r = st_i.rem_r - 16'd1;
      if (st_i.rem_r == 16'd1) s_tick_r = ebdc_pkg::speed_apply(s_tick_r, st_i.spd_l, 8'd0);
    end

    bal_ok = (s_tick_r.spd_l == s_tick_r.spd_r) && (s_tick_r.spd_l != 8'd0) &&
             (s_tick_r.cnt_r != s_tick_r.cnt_l) && !s_tick_r.cnt_r[31] &&
             (s_tick_r.cnt_r > 32'd1);

    unique case (s_tick_r.mode)
      ebdc_pkg::DIR_FWD: diff = s_tick_r.cnt_r - s_tick_r.cnt_l;
      ebdc_pkg::DIR_BWD: diff = s_tick_r.cnt_l - s_tick_r.cnt_r;
      ebdc_pkg::DIR_TL:  diff = s_tick_r.cnt_r + s_tick_r.cnt_l;
      default:           diff = 32'd0 - (s_tick_r.cnt_r + s_tick_r.cnt_l);
    endcase

    if (diff[31]) begin
      nud = ebdc_pkg::nudge(s_tick_r.pwm_r, s_tick_r.pwm_l, s_tick_r.spd_l);
    end else begin
      nud = ebdc_pkg::nudge(s_tick_r.pwm_l, s_tick_r.pwm_r, s_tick_r.spd_l);
    end

    if (bal_ok) begin
      // duty moves only in drive and turn modes; counts clear regardless
      if (s_tick_r.mode <= ebdc_pkg::DIR_TR) begin
        if (diff[31]) begin
          s_tick_r.pwm_r = nud[15:8];
          s_tick_r.pwm_l = nud[7:0];
        end else if (diff != 32'd0) begin
          s_tick_r.pwm_l = nud[15:8];
          s_tick_r.pwm_r = nud[7:0];
        end
      end
      s_tick_r.cnt_l = '0;
      s_tick_r.cnt_r = '0;
    end
  end

  always_comb begin
    s_tick_l = st_i;
    unique case (st_i.mode)
      ebdc_pkg::DIR_FWD, ebdc_pkg::DIR_TR: s_tick_l.cnt_l = st_i.cnt_l + 32'd1;
      ebdc_pkg::DIR_BWD, ebdc_pkg::DIR_TL: s_tick_l.cnt_l = st_i.cnt_l - 32'd1;
      default: ;
    endcase
    if (st_i.rem_l != 16'd0) begin
      s_tick_l.rem_l = st_i.rem_l - 16'd1;
      if (st_i.rem_l == 16'd1) s_tick_l = ebdc_pkg::speed_apply(s_tick_l, 8'd0, st_i.spd_r);
    end
  end

  always_comb begin
    s_stop        = st_i;
    s_stop.pwm_l  = '0;
    s_stop.pwm_r  = '0;
    s_stop.spd_l  = '0;
    s_stop.spd_r  = '0;
    s_stop.cnt_l  = '0;
    s_stop.cnt_r  = '0;
    s_stop        = ebdc_pkg::dir_apply(s_stop, ebdc_pkg::DIR_BRAKE);
    s_stop.lamp_l = 1'b0;
    s_stop.lamp_r = 1'b0;
  end

  always_comb begin
    st_o = st_i;
    unique case (kind_i)
      ebdc_pkg::KIND_TICK_R:  st_o = s_tick_r;
      ebdc_pkg::KIND_TICK_L:  st_o = s_tick_l;
      ebdc_pkg::KIND_SPEED:   st_o = ebdc_pkg::speed_apply(st_i, vl_i[7:0], vr_i[7:0]);
      ebdc_pkg::KIND_DIR:     st_o = ebdc_pkg::dir_apply(st_i, dir_i);
      ebdc_pkg::KIND_TARGETS: begin
        st_o.rem_l = vl_i;
        st_o.rem_r = vr_i;
      end
      ebdc_pkg::KIND_STOP:    st_o = s_stop;
      default: ;
    endcase
  end

endmodule

// ===== src/encoder_balanced_drive_controller.sv =====
`timescale 1ns / 1ps

// channel | dir | data                                        | user
// in      | in  | value_left, value_right, direction          | kind
// out     | out | duty_l/r, bridge_l/r, lamp_l/r, done, mode  | -
//
// one beat in, one beat out; a beat can be taken every cycle while the output is not stalled
// a beat passes the input register, then the state and result register
// the event step is a single combinational pass on the held state
// synchronous active-low reset: state goes to forward, all zero, bridges off
// a stalled result holds; one more beat is taken into the input register

module encoder_balanced_drive_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_left[15:0], value_right[31:16], direction[34:32]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // duty_left[7:0], duty_right[15:8], bridge_left[17:16],
                                  // bridge_right[19:18], lamp_left[20], lamp_right[21],
                                  // targets_done[22], mode_now[25:23]
);

  logic             in_valid_r;
  logic [2:0]       kind_r;
  logic [15:0]      vl_r;
  logic [15:0]      vr_r;
  logic [2:0]       dir_r;
  ebdc_pkg::state_t st_r;
  ebdc_pkg::state_t st_nxt;
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic [31:0]      out_data_nxt;
  logic             adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  ebdc_step u_step (
    .st_i   (st_r),
    .kind_i (kind_r),
    .vl_i   (vl_r),
    .vr_i   (vr_r),
    .dir_i  (dir_r),
    .st_o   (st_nxt)
  );

  assign out_data_nxt = {6'd0, st_nxt.mode,
                         (st_nxt.rem_l == 16'd0) && (st_nxt.rem_r == 16'd0),
                         st_nxt.lamp_r, st_nxt.lamp_l, st_nxt.br_r, st_nxt.br_l,
                         st_nxt.pwm_r, st_nxt.pwm_l};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      vl_r   <= in_tdata[15:0];
      vr_r   <= in_tdata[31:16];
      dir_r  <= in_tdata[34:32];
    end
    if (adv) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // brake modes leave their side's bridge off
  a_brake_off: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == ebdc_pkg::DIR_BRAKE |->
      (st_r.br_l == ebdc_pkg::BR_OFF) && (st_r.br_r == ebdc_pkg::BR_OFF))
    else $error("brake mode with a bridge driven");

  a_brake_l_off: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == ebdc_pkg::DIR_BRAKE_L |-> st_r.br_l == ebdc_pkg::BR_OFF)
    else $error("brake left with left bridge driven");

  // lamps follow the set speeds
  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.lamp_l == (st_r.spd_l != 8'd0)) && (st_r.lamp_r == (st_r.spd_r != 8'd0)))
    else $error("indicator out of step with set speed");

  // a duty is nonzero only while its wheel has a set speed
  a_duty_speed: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r.pwm_l == 8'd0) || (st_r.spd_l != 8'd0)) &&
    ((st_r.pwm_r == 8'd0) || (st_r.spd_r != 8'd0)))
    else $error("duty running without set speed");

  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid && (out_tdata == $past(out_data_nxt)))
    else $error("stepped beat not presented");

endmodule
